// ===== hw/rtl/pcx_rle_pkg.sv =====
// ----------------------------------------------------------------------------
// PCX RLE decoder package
// Shared types and constants for the run-length pixel decoder.
// ----------------------------------------------------------------------------
package pcx_rle_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned RUN_W   = 6;
  localparam int unsigned INDEX_W = 2;

  localparam logic [BYTE_W-1:0] MARK_BITS = 8'hc0;
  localparam logic [BYTE_W-1:0] LEN_MASK  = 8'h3f;

  localparam logic [CFG_W-1:0] CFG_RESET = 16'd1;

  // Configuration register indexes
  localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [INDEX_W-1:0] REG_LINE_BYTES   = 2'd1;
  localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXPAND
  } state_t;

  typedef struct packed {
    logic load;   // take the input byte
    logic step;   // advance the expansion by one position
  } cmd_t;

  typedef struct packed {
    logic expand_go;  // offered byte starts an expansion
    logic run_end;    // expansion has no more positions to visit
  } status_t;

endpackage

// ===== hw/rtl/pcx_rle_ctrl.sv =====
// ----------------------------------------------------------------------------
// PCX RLE decoder controller
// Accepts bytes while idle and sequences the pixel expansion.
// ----------------------------------------------------------------------------
module pcx_rle_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pcx_rle_pkg::status_t status,
  output pcx_rle_pkg::cmd_t    cmd
);
  import pcx_rle_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && status.expand_go) state_next = ST_EXPAND;
      end
      ST_EXPAND: begin
        if (status.run_end) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXPAND: begin
        cmd.step = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/pcx_rle_dpath.sv =====
// ----------------------------------------------------------------------------
// PCX RLE decoder datapath
// Configuration, line and run counters, and the pixel output register.
// ----------------------------------------------------------------------------
module pcx_rle_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  pcx_rle_pkg::cmd_t                   cmd,
  output pcx_rle_pkg::status_t                status,
  input  logic                                cfg_we,
  input  logic [pcx_rle_pkg::INDEX_W-1:0]     cfg_index,
  input  logic [pcx_rle_pkg::CFG_W-1:0]       cfg_data,
  input  logic [pcx_rle_pkg::BYTE_W-1:0]      data_byte,
  input  logic                                new_image,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pcx_rle_pkg::BYTE_W-1:0]      pixel_value,
  output logic [pcx_rle_pkg::CFG_W-1:0]       column,
  output logic [pcx_rle_pkg::CFG_W-1:0]       row,
  output logic                                last_of_item,
  output logic                                last_of_image
);
  import pcx_rle_pkg::*;

  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  line_bytes;
  logic [CFG_W-1:0]  image_height;

  logic              awaiting_value;
  logic [RUN_W-1:0]  run_length;
  logic [CFG_W-1:0]  byte_column;
  logic [CFG_W-1:0]  line_number;
  logic              image_finished;

  logic [RUN_W-1:0]  remaining;
  logic [BYTE_W-1:0] run_value;

  // State as seen by the offered byte, after an optional image restart
  logic              eff_await;
  logic [RUN_W-1:0]  eff_run;
  logic [CFG_W-1:0]  eff_column;
  logic [CFG_W-1:0]  eff_line;
  logic              eff_finished;

  logic              skip;
  logic              is_marker;
  logic              expand_go;
  logic [CFG_W-1:0]  cap;
  logic [CFG_W:0]    column_inc;
  logic [CFG_W:0]    line_inc;
  logic              run_end;
  logic              in_cap;
  logic              out_free;
  logic              emit;

  assign eff_await    = new_image ? 1'b0 : awaiting_value;
  assign eff_run      = new_image ? '0 : run_length;
  assign eff_column   = new_image ? '0 : byte_column;
  assign eff_line     = new_image ? '0 : line_number;
  assign eff_finished = new_image ? 1'b0 : image_finished;

  assign skip      = eff_finished || (eff_line >= image_height);
  assign is_marker = (data_byte & MARK_BITS) == MARK_BITS;
  assign expand_go = !skip && (eff_await || !is_marker);

  assign cap        = (image_width < line_bytes) ? image_width : line_bytes;
  assign column_inc = {1'b0, byte_column} + {{CFG_W{1'b0}}, 1'b1};
  assign line_inc   = {1'b0, line_number} + {{CFG_W{1'b0}}, 1'b1};
  assign run_end    = (remaining == '0) || (byte_column >= line_bytes);
  assign in_cap     = byte_column < cap;
  assign out_free   = !out_valid || out_ready;
  assign emit       = cmd.step && !run_end && in_cap && out_free;

  assign status = '{expand_go: expand_go, run_end: run_end};

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= CFG_RESET;
      line_bytes     <= CFG_RESET;
      image_height   <= CFG_RESET;
      awaiting_value <= 1'b0;
      run_length     <= '0;
      byte_column    <= '0;
      line_number    <= '0;
      image_finished <= 1'b0;
      remaining      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          REG_LINE_BYTES:   line_bytes   <= cfg_data;
          REG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.load) begin
        byte_column    <= eff_column;
        line_number    <= eff_line;
        image_finished <= skip;
        if (skip) begin
          awaiting_value <= eff_await;
          run_length     <= eff_run;
        end else if (eff_await) begin
          awaiting_value <= 1'b0;
          run_length     <= eff_run;
          remaining      <= eff_run;
        end else if (is_marker) begin
          awaiting_value <= 1'b1;
          run_length     <= RUN_W'(data_byte & LEN_MASK);
        end else begin
          awaiting_value <= 1'b0;
          run_length     <= eff_run;
          remaining      <= RUN_W'(1);
        end
      end

      if (cmd.step) begin
        if (run_end) begin
          // wrap to the next line once the padding is passed
          if (byte_column >= line_bytes) begin
            byte_column <= '0;
            line_number <= line_inc[CFG_W-1:0];
            if ((line_inc[CFG_W-1:0] >= image_height) || (line_inc[CFG_W-1:0] == '0)) begin
              image_finished <= 1'b1;
            end
          end
        end else if (!in_cap || out_free) begin
          // padding columns advance without a pixel; visible ones wait for room
          byte_column <= column_inc[CFG_W-1:0];
          remaining   <= remaining - RUN_W'(1);
        end
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      run_value <= data_byte;
    end
    if (emit) begin
      pixel_value   <= run_value;
      column        <= byte_column;
      row           <= line_number;
      last_of_item  <= (remaining == RUN_W'(1)) || (column_inc >= {1'b0, cap});
      last_of_image <= (line_inc == {1'b0, image_height}) && (column_inc == {1'b0, cap});
    end
  end

endmodule

// ===== hw/rtl/pcx_rle_pixel_decoder_core.sv =====
// ----------------------------------------------------------------------------
// PCX RLE pixel decoder core
// Expands the run-length coded pixel stream of an 8-bit PCX image.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one compressed byte per
//   transfer, with new_image set on the first byte of an image. Output
//   channel (out_valid/out_ready) carries one pixel per transfer with its
//   column, row and end-of-byte / end-of-image flags.
//   Configure image_width, line_bytes and image_height through cfg_we,
//   cfg_index and cfg_data while the block is idle.
// Timing:
//   A run marker, or a byte arriving after the image has ended, is taken
//   while the controller stays idle. A pixel or value byte is expanded over
//   the N line positions its run covers (N at most 63): the controller visits one
//   position per cycle, but waits at visible ones while the receiver stalls.
//   The first pixel is registered once the controller is in its expand state.
// Reset clears all counters and sets the three registers to 1.
// When the receiver stalls, the pixel is held in the output register and
// the expansion waits; the input is not taken until the run is finished.
// ----------------------------------------------------------------------------
module pcx_rle_pixel_decoder_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pcx_rle_pkg::INDEX_W-1:0] cfg_index,
  input  logic [pcx_rle_pkg::CFG_W-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pcx_rle_pkg::BYTE_W-1:0]  data_byte,
  input  logic                            new_image,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pcx_rle_pkg::BYTE_W-1:0]  pixel_value,
  output logic [pcx_rle_pkg::CFG_W-1:0]   column,
  output logic [pcx_rle_pkg::CFG_W-1:0]   row,
  output logic                            last_of_item,
  output logic                            last_of_image
);
  import pcx_rle_pkg::*;

  cmd_t    cmd;
  status_t status;

  pcx_rle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pcx_rle_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .data_byte     (data_byte),
    .new_image     (new_image),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_value   (pixel_value),
    .column        (column),
    .row           (row),
    .last_of_item  (last_of_item),
    .last_of_image (last_of_image)
  );

endmodule
